// ===== sv/tcgr_pkg.sv =====
// tcgr_pkg: shared constants, widths and the palette for the text cell glyph renderer
// no dependencies; imported by tcgr_font_mem and text_cell_glyph_renderer
package tcgr_pkg;

    localparam int GLYPH_HEIGHT_DEF = 14;
    localparam int GLYPH_COUNT_DEF  = 256;
    localparam int CELL_WIDTH       = 8;

    localparam int CODE_W   = 8;
    localparam int LINE_W   = 4;
    localparam int INDEX_W  = 4;
    localparam int RGB_W    = 24;
    localparam int ADDR_W   = 26;
    localparam int COORD_W  = 12;
    localparam int GRID_W   = 8;
    localparam int PITCH_W  = 13;
    localparam int POS_W    = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 3'd4;

    localparam logic [GRID_W-1:0]  GRID_COLUMNS_RST = 8'd100;
    localparam logic [GRID_W-1:0]  GRID_ROWS_RST    = 8'd40;
    localparam logic [PITCH_W-1:0] LINE_PITCH_RST   = 13'd1024;

    localparam logic [CELL_WIDTH-1:0] MASK_ALL = 8'hFF;

    function automatic logic [RGB_W-1:0] palette_rgb(input logic [INDEX_W-1:0] idx);
        logic [RGB_W-1:0] rgb;
        unique case (idx)
            4'd0:    rgb = 24'h000000;
            4'd1:    rgb = 24'h000080;
            4'd2:    rgb = 24'h008000;
            4'd3:    rgb = 24'h008080;
            4'd4:    rgb = 24'h800000;
            4'd5:    rgb = 24'h800080;
            4'd6:    rgb = 24'h808000;
            4'd7:    rgb = 24'hC0C0C0;
            4'd8:    rgb = 24'h808080;
            4'd9:    rgb = 24'h0000FF;
            4'd10:   rgb = 24'h00FF00;
            4'd11:   rgb = 24'h00FFFF;
            4'd12:   rgb = 24'hFF0000;
            4'd13:   rgb = 24'hFF00FF;
            4'd14:   rgb = 24'hFFFF00;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

// ===== sv/tcgr_font_mem.sv =====
// tcgr_font_mem: glyph row store, one write port and one registered read port
// depends on tcgr_pkg for the glyph row width
module tcgr_font_mem #(
    parameter int DEPTH = 3584,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic [tcgr_pkg::CELL_WIDTH-1:0] wdata,
    input  logic                           re,
    input  logic [AW-1:0]                  raddr,
    output logic [tcgr_pkg::CELL_WIDTH-1:0] rdata
);
    import tcgr_pkg::*;

    logic [CELL_WIDTH-1:0] mem [DEPTH];
    logic [CELL_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/text_cell_glyph_renderer.sv =====
// text_cell_glyph_renderer: 8-pixel-wide bitmap font cell renderer for a 32 bpp frame buffer
// depends on tcgr_pkg and tcgr_font_mem
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+---------------------------------------
//  in      | input     | in_valid / in_stall  | load of one glyph row or draw of a cell
//  out     | output    | out_valid / out_stall| one row write: address, 8 pixels, mask
//  cfg     | input     | cfg_we               | grid size, origin, line pitch
//
// a load writes one glyph row into the font store and the block stays ready
// a draw inside the grid goes through the address multiply, one font read per row,
// the output register and the handover to the out channel
// in_stall is high from the accepted draw until its last row word is taken
// out_stall holds the output register; reads stop once the read register is also full
// rst_n clears control state and loads the register reset values; the font store is not cleared
module text_cell_glyph_renderer #(
    parameter int GLYPH_HEIGHT = tcgr_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT  = tcgr_pkg::GLYPH_COUNT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic [tcgr_pkg::GRID_W-1:0]      cell_column,
    input  logic [tcgr_pkg::GRID_W-1:0]      cell_row,
    input  logic [tcgr_pkg::INDEX_W-1:0]     fore_index,
    input  logic [tcgr_pkg::INDEX_W-1:0]     back_index,
    input  logic                             transparent,
    input  logic [tcgr_pkg::CODE_W-1:0]      char_code,
    input  logic [tcgr_pkg::LINE_W-1:0]      glyph_line,
    input  logic [tcgr_pkg::CELL_WIDTH-1:0]  glyph_bits,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tcgr_pkg::ADDR_W-1:0]      byte_address,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_0,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_1,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_2,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_3,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_4,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_5,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_6,
    output logic [tcgr_pkg::RGB_W-1:0]       pixel_7,
    output logic [tcgr_pkg::CELL_WIDTH-1:0]  write_mask,
    output logic                             last_row
);
    import tcgr_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GLYPH_HEIGHT + 1);
    localparam int PROD_W = 2 * POS_W + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BASE = 2'd1;
    localparam logic [1:0] ST_ROWS = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [GRID_W-1:0]       grid_columns_reg;
    logic [GRID_W-1:0]       grid_rows_reg;
    logic [COORD_W-1:0]      origin_x_reg;
    logic [COORD_W-1:0]      origin_y_reg;
    logic [PITCH_W-1:0]      line_pitch_reg;

    logic [POS_W-1:0]        x0_reg;
    logic [POS_W-1:0]        y0_reg;
    logic [AW-1:0]           glyph_base_reg;
    logic                    code_ok_reg;
    logic                    transp_reg;
    logic [RGB_W-1:0]        fore_rgb_reg;
    logic [RGB_W-1:0]        back_rgb_reg;

    logic [RW-1:0]           fetch_row_reg, fetch_row_next;
    logic [RW-1:0]           mem_row_reg;
    logic                    mem_vld_reg, mem_vld_next;
    logic                    out_vld_reg, out_vld_next;
    logic                    out_last_reg;
    logic [CELL_WIDTH-1:0]   out_bits_reg;
    logic [ADDR_W-1:0]       out_addr_reg;
    logic [ADDR_W-1:0]       row_addr_reg;

    logic                    in_take;
    logic                    code_in_font;
    logic                    load_ok;
    logic                    draw_ok;
    logic                    out_adv;
    logic                    move;
    logic                    issue;
    logic                    done;
    logic [PROD_W-1:0]       base_sum;
    logic [AW-1:0]           load_addr;
    logic [AW-1:0]           rd_addr;
    logic [CELL_WIDTH-1:0]   rd_data;
    logic [RGB_W-1:0]        clear_rgb;
    logic [RGB_W-1:0]        pixels [CELL_WIDTH];

    tcgr_font_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_font_mem (
        .clk   (clk),
        .we    (load_ok),
        .waddr (load_addr),
        .wdata (glyph_bits),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        in_take      = in_valid && !in_stall;
        code_in_font = {1'b0, char_code} < (CODE_W + 1)'(GLYPH_COUNT);
        load_ok      = in_take && !func && code_in_font
                       && ({1'b0, glyph_line} < (LINE_W + 1)'(GLYPH_HEIGHT));
        draw_ok      = in_take && func && (cell_column < grid_columns_reg)
                       && (cell_row < grid_rows_reg);
        load_addr    = AW'(int'(char_code) * GLYPH_HEIGHT + int'(glyph_line));
        rd_addr      = glyph_base_reg + AW'(fetch_row_reg);
        out_adv      = !out_vld_reg || !out_stall;
        move         = mem_vld_reg && out_adv;
        issue        = (state_reg == ST_ROWS) && (fetch_row_reg < RW'(GLYPH_HEIGHT))
                       && (!mem_vld_reg || out_adv);
        done         = out_vld_reg && !out_stall && out_last_reg;
        base_sum     = PROD_W'(y0_reg) * PROD_W'(line_pitch_reg) + PROD_W'(x0_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (draw_ok)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                state_next = ST_ROWS;
            end
            ST_ROWS:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fetch_row_next = fetch_row_reg;
        if (state_reg == ST_BASE)
        begin
            fetch_row_next = '0;
        end
        else if (issue)
        begin
            fetch_row_next = fetch_row_reg + RW'(1);
        end

        mem_vld_next = mem_vld_reg;
        if (issue)
        begin
            mem_vld_next = 1'b1;
        end
        else if (move)
        begin
            mem_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (out_adv)
        begin
            out_vld_next = move;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            grid_columns_reg <= GRID_COLUMNS_RST;
            grid_rows_reg    <= GRID_ROWS_RST;
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            line_pitch_reg   <= LINE_PITCH_RST;
            fetch_row_reg    <= '0;
            mem_vld_reg      <= 1'b0;
            out_vld_reg      <= 1'b0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fetch_row_reg <= fetch_row_next;
            mem_vld_reg   <= mem_vld_next;
            out_vld_reg   <= out_vld_next;
            if (move)
            begin
                out_last_reg <= (mem_row_reg == RW'(GLYPH_HEIGHT - 1));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GRID_COLUMNS: grid_columns_reg <= cfg_data[GRID_W-1:0];
                    REG_GRID_ROWS:    grid_rows_reg    <= cfg_data[GRID_W-1:0];
                    REG_ORIGIN_X:     origin_x_reg     <= cfg_data[COORD_W-1:0];
                    REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[COORD_W-1:0];
                    REG_LINE_PITCH:   line_pitch_reg   <= cfg_data[PITCH_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (draw_ok)
        begin
            x0_reg         <= POS_W'({cell_column, 3'b000}) + POS_W'(origin_x_reg);
            y0_reg         <= POS_W'(int'(cell_row) * GLYPH_HEIGHT) + POS_W'(origin_y_reg);
            glyph_base_reg <= AW'(int'(char_code) * GLYPH_HEIGHT);
            code_ok_reg    <= code_in_font;
            transp_reg     <= transparent;
            fore_rgb_reg   <= palette_rgb(fore_index);
            back_rgb_reg   <= palette_rgb(back_index);
        end
        if (state_reg == ST_BASE)
        begin
            row_addr_reg <= {base_sum[ADDR_W-3:0], 2'b00};
        end
        else if (move)
        begin
            row_addr_reg <= row_addr_reg + ADDR_W'({line_pitch_reg, 2'b00});
        end
        if (issue)
        begin
            mem_row_reg <= fetch_row_reg;
        end
        if (move)
        begin
            out_bits_reg <= code_ok_reg ? rd_data : '0;
            out_addr_reg <= row_addr_reg;
        end
    end

    always_comb
    begin
        clear_rgb = transp_reg ? '0 : back_rgb_reg;
        for (int i = 0; i < CELL_WIDTH; i++)
        begin
            pixels[i] = out_bits_reg[CELL_WIDTH-1-i] ? fore_rgb_reg : clear_rgb;
        end
    end

    assign in_stall     = (state_reg != ST_IDLE);
    assign out_valid    = out_vld_reg;
    assign byte_address = out_addr_reg;
    assign pixel_0      = pixels[0];
    assign pixel_1      = pixels[1];
    assign pixel_2      = pixels[2];
    assign pixel_3      = pixels[3];
    assign pixel_4      = pixels[4];
    assign pixel_5      = pixels[5];
    assign pixel_6      = pixels[6];
    assign pixel_7      = pixels[7];
    assign write_mask   = transp_reg ? out_bits_reg : MASK_ALL;
    assign last_row     = out_last_reg;

endmodule
